// ===== hw/rtl/greedy_change_dispenser_defines.svh =====
// Assertion macros for the change dispenser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef GREEDY_CHANGE_DISPENSER_DEFINES_SVH
`define GREEDY_CHANGE_DISPENSER_DEFINES_SVH
`ifndef SYNTHESIS
// Assertion on clk_i, disabled while rst_ni is low.
`define GCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Assertion on an explicit clock and active-low reset.
`define GCD_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);
`else
`define GCD_ASSERT(lbl, prop, msg)
`define GCD_ASSERT_CLK(lbl, clk, rst, prop, msg)
`endif
`endif

// ===== hw/rtl/gcd_pkg.sv =====
// Package of the change dispenser: widths, status codes and the denomination table.
// No dependencies.
`default_nettype none
package gcd_pkg;

  localparam int DenomSlots   = 9;
  localparam int NumDenoms    = 9;
  localparam int ActiveDenoms = (NumDenoms > DenomSlots) ? DenomSlots : NumDenoms;
  localparam int IdxW         = $clog2(DenomSlots);
  localparam int AmtW         = 16;
  localparam int CntW         = 8;
  localparam int NotesW       = 10;
  localparam int CoinsW       = 11;
  localparam int StatusW      = 2;
  localparam int ValueW       = 9;
  localparam int ShiftW       = 3;
  localparam int RecipW       = 17;
  localparam int PostW        = 5;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusShort   = 2'd1;
  localparam logic [StatusW-1:0] StatusNoStock = 2'd2;

  // One denomination: value in half-dirham units, value = (1 << shift) * m,
  // and floor(x / m) = (x * recip) >> post for every 16-bit x.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [ShiftW-1:0] shift;
    logic [RecipW-1:0] recip;
    logic [PostW-1:0]  post;
    logic              note;
    logic [CntW-1:0]   init;
  } denom_t;

  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [CntW-1:0] wr_data;
    logic            commit;
  } store_req_t;

  function automatic denom_t denom_info(input logic [IdxW-1:0] idx);
    denom_t d;
    case (idx)
      4'd0:    d = '{9'd400, 3'd4, 17'd83887, 5'd21, 1'b1, 8'd0};
      4'd1:    d = '{9'd200, 3'd3, 17'd83887, 5'd21, 1'b1, 8'd0};
      4'd2:    d = '{9'd100, 3'd2, 17'd83887, 5'd21, 1'b1, 8'd0};
      4'd3:    d = '{9'd40,  3'd3, 17'd52429, 5'd18, 1'b1, 8'd0};
      4'd4:    d = '{9'd20,  3'd2, 17'd52429, 5'd18, 1'b0, 8'd5};
      4'd5:    d = '{9'd10,  3'd1, 17'd52429, 5'd18, 1'b0, 8'd3};
      4'd6:    d = '{9'd4,   3'd2, 17'd1,     5'd0,  1'b0, 8'd2};
      4'd7:    d = '{9'd2,   3'd1, 17'd1,     5'd0,  1'b0, 8'd6};
      4'd8:    d = '{9'd1,   3'd0, 17'd1,     5'd0,  1'b0, 8'd3};
      default: d = '{9'd1,   3'd0, 17'd1,     5'd0,  1'b0, 8'd0};
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gcd_ram.sv =====
// Single-bank stock RAM: one write port, one read port with registered data.
// Depends on gcd_pkg.
`default_nettype none
module gcd_ram (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [gcd_pkg::IdxW-1:0] waddr_i,
  input  wire logic [gcd_pkg::CntW-1:0] wdata_i,
  input  wire logic                     re_i,
  input  wire logic [gcd_pkg::IdxW-1:0] raddr_i,
  output logic      [gcd_pkg::CntW-1:0] rdata_o
);

  logic [gcd_pkg::CntW-1:0] mem_q [gcd_pkg::DenomSlots];
  logic [gcd_pkg::CntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/gcd_stock_store.sv =====
// Stock store: two RAM banks, one live and one shadow, swapped on commit.
// Depends on gcd_pkg, gcd_ram and the assertion macro header.
`default_nettype none
`include "greedy_change_dispenser_defines.svh"
module gcd_stock_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gcd_pkg::store_req_t      req_i,
  output logic      [gcd_pkg::CntW-1:0] rd_data_o
);

  logic                           bank_sel_q;
  logic [gcd_pkg::DenomSlots-1:0] valid_q [2];
  logic                           rd_bank_q;
  logic                           rd_valid_q;
  logic [gcd_pkg::IdxW-1:0]       rd_addr_q;
  logic [gcd_pkg::CntW-1:0]       rdata0, rdata1;
  logic                           we0, we1;
  gcd_pkg::denom_t                rd_info;

  // Reads go to the live bank, writes to the shadow bank, so they never collide.
  assign we0 = req_i.wr_en &  bank_sel_q;
  assign we1 = req_i.wr_en & ~bank_sel_q;

  gcd_ram u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_data),
    .re_i   (req_i.rd_en & ~bank_sel_q),
    .raddr_i(req_i.rd_addr),
    .rdata_o(rdata0)
  );

  gcd_ram u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(req_i.wr_addr),
    .wdata_i(req_i.wr_data),
    .re_i   (req_i.rd_en & bank_sel_q),
    .raddr_i(req_i.rd_addr),
    .rdata_o(rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q <= 1'b0;
      valid_q[0] <= '0;
      valid_q[1] <= '0;
      rd_bank_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (req_i.rd_en) begin
        rd_bank_q  <= bank_sel_q;
        rd_valid_q <= valid_q[bank_sel_q][req_i.rd_addr];
        rd_addr_q  <= req_i.rd_addr;
      end
      if (req_i.wr_en) begin
        valid_q[~bank_sel_q][req_i.wr_addr] <= 1'b1;
      end
      if (req_i.commit) begin
        bank_sel_q <= ~bank_sel_q;
      end
    end
  end

  // An entry never written still holds its reset stock.
  assign rd_info   = gcd_pkg::denom_info(rd_addr_q);
  assign rd_data_o = rd_valid_q ? (rd_bank_q ? rdata1 : rdata0) : rd_info.init;

  `GCD_ASSERT(a_commit_full_shadow, req_i.commit |-> (&valid_q[~bank_sel_q]), "commit of partly written shadow bank")
  `GCD_ASSERT(a_no_commit_while_write, req_i.commit |-> !req_i.wr_en, "commit during shadow write")

endmodule
`default_nettype wire

// ===== hw/rtl/gcd_quot.sv =====
// Quotient unit: floor(amount / denomination) by shift and reciprocal multiply.
// Depends on gcd_pkg.
`default_nettype none
module gcd_quot (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [gcd_pkg::AmtW-1:0] amount_i,
  input  wire logic [gcd_pkg::IdxW-1:0] idx_i,
  output logic      [gcd_pkg::AmtW-1:0] quot_o
);

  localparam int ProdW = gcd_pkg::AmtW + gcd_pkg::RecipW;

  gcd_pkg::denom_t          info;
  logic [gcd_pkg::AmtW-1:0] scaled;
  logic [ProdW-1:0]         prod;
  logic [ProdW-1:0]         shifted;
  logic [gcd_pkg::AmtW-1:0] quot_q;

  assign info    = gcd_pkg::denom_info(idx_i);
  assign scaled  = amount_i >> info.shift;
  assign prod    = ProdW'(scaled) * ProdW'(info.recip);
  assign shifted = prod >> info.post;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= shifted[gcd_pkg::AmtW-1:0];
    end
  end

  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== hw/rtl/greedy_change_dispenser.sv =====
// Greedy change dispenser, top level: control sequencer, counters, result register.
// Depends on gcd_pkg, gcd_stock_store, gcd_quot and the assertion macro header.
//
//   channel | handshake               | word
//   --------+-------------------------+-----------------------------------------
//   in      | in_valid_i/in_ready_o   | price_i, paid_i
//   out     | out_valid_o/out_ready_i | status_o, count_*_o, notes_total_o,
//           |                         | coins_total_o
//
// A transaction runs from the cycle in which the word is accepted to the one
// that loads the result: accept, then for all nine slots a quotient multiply
// and a stock update per denomination, then commit. A short payment skips the
// scan and goes straight from accept to commit. The stock RAM read port and
// the quotient multiplier are each used once per denomination.
// After reset the stock holds its initial counts at once; no clearing pass.
// A new word is accepted while a result waits; the commit cycle waits for
// the result register to be free.
`default_nettype none
`include "greedy_change_dispenser_defines.svh"
module greedy_change_dispenser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gcd_pkg::AmtW-1:0]    price_i,
  input  wire logic [gcd_pkg::AmtW-1:0]    paid_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [gcd_pkg::StatusW-1:0] status_o,
  output logic      [gcd_pkg::CntW-1:0]    count_200_o,
  output logic      [gcd_pkg::CntW-1:0]    count_100_o,
  output logic      [gcd_pkg::CntW-1:0]    count_50_o,
  output logic      [gcd_pkg::CntW-1:0]    count_20_o,
  output logic      [gcd_pkg::CntW-1:0]    count_10_o,
  output logic      [gcd_pkg::CntW-1:0]    count_5_o,
  output logic      [gcd_pkg::CntW-1:0]    count_2_o,
  output logic      [gcd_pkg::CntW-1:0]    count_1_o,
  output logic      [gcd_pkg::CntW-1:0]    count_half_o,
  output logic      [gcd_pkg::NotesW-1:0]  notes_total_o,
  output logic      [gcd_pkg::CoinsW-1:0]  coins_total_o
);

  // Sequencer states: idle, quotient multiply, stock update, commit.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  localparam logic [gcd_pkg::IdxW-1:0] LastIdx   = gcd_pkg::IdxW'(gcd_pkg::DenomSlots - 1);
  localparam logic [gcd_pkg::IdxW-1:0] ActiveLim = gcd_pkg::IdxW'(gcd_pkg::ActiveDenoms);

  logic [1:0]                  state_q, state_d;
  logic [gcd_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [gcd_pkg::AmtW-1:0]    left_q, left_d;
  logic                        short_q, short_d;
  logic [gcd_pkg::CntW-1:0]    cnt_q [gcd_pkg::DenomSlots];
  logic [gcd_pkg::NotesW-1:0]  notes_q;
  logic [gcd_pkg::CoinsW-1:0]  coins_q;

  logic                        out_valid_q;
  logic [gcd_pkg::StatusW-1:0] out_status_q;
  logic [gcd_pkg::CntW-1:0]    out_cnt_q [gcd_pkg::DenomSlots];
  logic [gcd_pkg::NotesW-1:0]  out_notes_q;
  logic [gcd_pkg::CoinsW-1:0]  out_coins_q;

  gcd_pkg::store_req_t         store_req;
  logic [gcd_pkg::CntW-1:0]    stock_rd;
  logic [gcd_pkg::AmtW-1:0]    quot;
  gcd_pkg::denom_t             cur_info;
  logic [gcd_pkg::CntW-1:0]    take;
  logic [gcd_pkg::AmtW:0]      spent;
  logic                        accept;
  logic                        out_free;
  logic                        exact;
  logic                        upd;
  logic                        clear_cnt;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;
  assign exact    = ~short_q & (left_q == '0);
  assign upd      = (state_q == StUpd);

  gcd_stock_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_data_o(stock_rd)
  );

  gcd_quot u_quot (
    .clk_i   (clk_i),
    .en_i    (state_q == StMul),
    .amount_i(left_q),
    .idx_i   (idx_q),
    .quot_o  (quot)
  );

  // Pieces taken: the quotient capped by stock, none for slots left out.
  assign cur_info = gcd_pkg::denom_info(idx_q);
  always_comb begin
    if (idx_q >= ActiveLim) begin
      take = '0;
    end else if (quot < gcd_pkg::AmtW'(stock_rd)) begin
      take = quot[gcd_pkg::CntW-1:0];
    end else begin
      take = stock_rd;
    end
  end
  assign spent = (gcd_pkg::AmtW+1)'(take) * (gcd_pkg::AmtW+1)'(cur_info.value);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    left_d    = left_q;
    short_d   = short_q;
    clear_cnt = 1'b0;
    store_req = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          short_d           = (paid_i < price_i);
          left_d            = paid_i - price_i;
          idx_d             = '0;
          clear_cnt         = 1'b1;
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = '0;
          state_d           = (paid_i < price_i) ? StFin : StMul;
        end
      end
      StMul: begin
        state_d = StUpd;
      end
      StUpd: begin
        left_d            = left_q - spent[gcd_pkg::AmtW-1:0];
        store_req.wr_en   = 1'b1;
        store_req.wr_addr = idx_q;
        store_req.wr_data = stock_rd - take;
        if (idx_q == LastIdx) begin
          state_d = StFin;
        end else begin
          idx_d             = idx_q + gcd_pkg::IdxW'(1);
          store_req.rd_en   = 1'b1;
          store_req.rd_addr = idx_q + gcd_pkg::IdxW'(1);
          state_d           = StMul;
        end
      end
      StFin: begin
        if (out_free) begin
          store_req.commit = exact;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == StFin) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the transaction.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    left_q  <= left_d;
    short_q <= short_d;
    if (clear_cnt) begin
      for (int i = 0; i < gcd_pkg::DenomSlots; i++) begin
        cnt_q[i] <= '0;
      end
      notes_q <= '0;
      coins_q <= '0;
    end else if (upd) begin
      cnt_q[idx_q] <= take;
      if (cur_info.note) begin
        notes_q <= notes_q + gcd_pkg::NotesW'(take);
      end else begin
        coins_q <= coins_q + gcd_pkg::CoinsW'(take);
      end
    end
  end

  // Result register: counts only go out when the change came out exact.
  always_ff @(posedge clk_i) begin
    if ((state_q == StFin) && out_free) begin
      out_status_q <= short_q ? gcd_pkg::StatusShort :
                      (exact ? gcd_pkg::StatusOk : gcd_pkg::StatusNoStock);
      for (int i = 0; i < gcd_pkg::DenomSlots; i++) begin
        out_cnt_q[i] <= exact ? cnt_q[i] : '0;
      end
      out_notes_q <= exact ? notes_q : '0;
      out_coins_q <= exact ? coins_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign count_200_o   = out_cnt_q[0];
  assign count_100_o   = out_cnt_q[1];
  assign count_50_o    = out_cnt_q[2];
  assign count_20_o    = out_cnt_q[3];
  assign count_10_o    = out_cnt_q[4];
  assign count_5_o     = out_cnt_q[5];
  assign count_2_o     = out_cnt_q[6];
  assign count_1_o     = out_cnt_q[7];
  assign count_half_o  = out_cnt_q[8];
  assign notes_total_o = out_notes_q;
  assign coins_total_o = out_coins_q;

  `GCD_ASSERT(a_commit_only_exact,
              store_req.commit |-> (!short_q && left_q == '0),
              "stock committed on failed change")
  `GCD_ASSERT(a_fail_zero_totals,
              (out_valid_o && status_o != gcd_pkg::StatusOk) |->
                (notes_total_o == '0 && coins_total_o == '0),
              "failed result carries pieces")
  `GCD_ASSERT(a_notes_sum,
              out_valid_o |-> (notes_total_o == gcd_pkg::NotesW'(count_200_o) +
                               gcd_pkg::NotesW'(count_100_o) +
                               gcd_pkg::NotesW'(count_50_o) +
                               gcd_pkg::NotesW'(count_20_o)),
              "note total mismatch")
  `GCD_ASSERT(a_no_scan_when_short, (state_q == StUpd) |-> !short_q, "scan run on short payment")

endmodule
`default_nettype wire
